// ----- design/spnbe16_pkg.sv -----
// ----------------------------------------------------------------------------
// spnbe16_pkg
// Shared constants and helper functions for the 16-bit SPN block cipher:
// block and key widths, the 4-bit S-box and the bit transposition.
// ----------------------------------------------------------------------------
package spnbe16_pkg;

  localparam int unsigned BLOCK_W   = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned NIBBLES   = BLOCK_W / NIBBLE_W;
  localparam int unsigned NUM_ROUNDS = 4;
  // Round keys slide by one nibble per round.
  localparam int unsigned KEY_STEP  = NIBBLE_W;

  typedef logic [BLOCK_W-1:0]  block_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [NIBBLE_W-1:0] nibble_t;

  localparam nibble_t SBOX [16] = '{
    4'h8, 4'hC, 4'hB, 4'h3, 4'h7, 4'h9, 4'h1, 4'h4,
    4'hE, 4'h6, 4'h0, 4'hD, 4'h2, 4'hF, 4'h5, 4'hA
  };

  // Apply the S-box to every nibble of the block.
  function automatic block_t sub_nibbles(block_t v);
    block_t o;
    o = '0;
    for (int n = 0; n < NIBBLES; n++) begin
      o[n*NIBBLE_W +: NIBBLE_W] = SBOX[v[n*NIBBLE_W +: NIBBLE_W]];
    end
    return o;
  endfunction

  // Bit i of nibble j moves to bit j of nibble i (4x4 bit-matrix transpose).
  function automatic block_t transpose(block_t v);
    block_t o;
    o = '0;
    for (int a = 0; a < NIBBLE_W; a++) begin
      for (int b = 0; b < NIBBLES; b++) begin
        o[a*NIBBLE_W + b] = v[b*NIBBLE_W + a];
      end
    end
    return o;
  endfunction

endpackage

// ----- design/spnbe16_round.sv -----
// ----------------------------------------------------------------------------
// spnbe16_round
// One cipher round core: round key mix followed by the nibble S-box layer.
// ----------------------------------------------------------------------------
module spnbe16_round (
  input  spnbe16_pkg::block_t state_i,
  input  spnbe16_pkg::block_t round_key_i,
  output spnbe16_pkg::block_t state_o
);

  assign state_o = spnbe16_pkg::sub_nibbles(state_i ^ round_key_i);

endmodule

// ----- design/spnbe16_cipher.sv -----
// ----------------------------------------------------------------------------
// spnbe16_cipher
// Combinational round chain: four key-mix/S-box rounds, a transposition after
// each of the first three and a final whitening key after the last.
// ----------------------------------------------------------------------------
module spnbe16_cipher (
  input  spnbe16_pkg::block_t plain_i,
  input  spnbe16_pkg::key_t   key_i,
  output spnbe16_pkg::block_t cipher_o
);

  localparam int unsigned NumRounds = spnbe16_pkg::NUM_ROUNDS;
  localparam int unsigned KeyW      = spnbe16_pkg::KEY_W;
  localparam int unsigned BlockW    = spnbe16_pkg::BLOCK_W;
  localparam int unsigned KeyStep   = spnbe16_pkg::KEY_STEP;

  spnbe16_pkg::block_t chain [NumRounds+1];
  spnbe16_pkg::block_t subbed [NumRounds];

  assign chain[0] = plain_i;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    spnbe16_round u_round (
      .state_i     (chain[r]),
      .round_key_i (key_i[KeyW-1-KeyStep*r -: BlockW]),
      .state_o     (subbed[r])
    );

    if (r == NumRounds - 1) begin : g_last
      // Last round: whitening key instead of the transposition.
      assign chain[r+1] = subbed[r] ^ key_i[KeyW-1-KeyStep*(r+1) -: BlockW];
    end else begin : g_mid
      assign chain[r+1] = spnbe16_pkg::transpose(subbed[r]);
    end
  end

  assign cipher_o = chain[NumRounds];

endmodule

// ----- design/spn_block_encrypt_16bit_top.sv -----
// ----------------------------------------------------------------------------
// spn_block_encrypt_16bit_top
// 16-bit four-round SPN encryptor with a configurable 32-bit master key.
// ----------------------------------------------------------------------------
// One plaintext block enters per cycle while plain_stall_o is low. The block
// is captured in an input register, all four rounds are evaluated in one
// combinational pass, and the ciphertext is held in an output
// register. Throughput is one block per cycle; back-pressure on the output
// stalls the input only when both registers are full. The key register is
// always ready and should be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module spn_block_encrypt_16bit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Key write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  spnbe16_pkg::key_t   cipher_key_i,
  // Plaintext channel
  input  logic                plain_valid_i,
  output logic                plain_stall_o,
  input  spnbe16_pkg::block_t plain_block_i,
  // Ciphertext channel
  output logic                cipher_valid_o,
  input  logic                cipher_stall_i,
  output spnbe16_pkg::block_t cipher_block_o
);

  spnbe16_pkg::key_t   key_q;
  spnbe16_pkg::block_t in_data_q;
  logic                in_valid_q;
  spnbe16_pkg::block_t out_data_q, out_data_d;
  logic                out_valid_q;
  logic                out_adv, in_adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_q <= cipher_key_i;
    end
  end

  // Output stage moves when empty or drained; input stage when it can hand off.
  assign out_adv       = !out_valid_q || !cipher_stall_i;
  assign in_adv        = !in_valid_q || out_adv;
  assign plain_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= plain_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && plain_valid_i) begin
      in_data_q <= plain_block_i;
    end
  end

  spnbe16_cipher u_cipher (
    .plain_i  (in_data_q),
    .key_i    (key_q),
    .cipher_o (out_data_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign cipher_valid_o = out_valid_q;
  assign cipher_block_o = out_data_q;

endmodule
